### rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Types and constants shared by the task table scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam int FUNC_W    = 2;
    localparam int PT_W      = 48;
    localparam int STATUS_W  = 3;
    localparam int TASK_ID_W = 11;
    localparam int SLOT_W    = 10;
    localparam int SST_W     = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_QUEUE    = 2'd0,
        FUNC_PREEMPT  = 2'd1,
        FUNC_FINISH   = 2'd2,
        FUNC_DISPATCH = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_QUEUED     = 3'd0,
        STS_SWITCHED   = 3'd1,
        STS_NOT_RUN    = 3'd2,
        STS_FULL       = 3'd3,
        STS_NO_OTHER   = 3'd4,
        STS_IDLE       = 3'd5
    } status_t;

    typedef enum logic [SST_W-1:0] {
        SLOT_QUEUED   = 2'd0,
        SLOT_RUNNING  = 2'd1,
        SLOT_PAUSED   = 2'd2,
        SLOT_FINISHED = 2'd3
    } slot_st_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_START
    } fsm_state_t;

    typedef struct packed {
        func_t           func;
        logic [PT_W-1:0] page_table_addr;
    } request_t;

    typedef struct packed {
        status_t              status;
        logic [TASK_ID_W-1:0] task_id;
        logic [SLOT_W-1:0]    prev_slot;
        logic                 run_valid;
        logic [SLOT_W-1:0]    run_slot;
        logic [PT_W-1:0]      run_page_table;
    } response_t;

    typedef struct packed {
        logic hit;
        logic none;
    } scan_status_t;

endpackage

`default_nettype wire

### rtl/task_table_scheduler_core.sv
// ----------------------------------------------------------------------------
// task_table_scheduler_core
// Task slot table with queue, preempt, finish and dispatch commands.
// ----------------------------------------------------------------------------
// Queue and rejected commands: done in the cycle after the transfer, busy stays low.
// Preempt, finish, dispatch: linear scan of the state RAM, one slot per cycle;
// done after the START state when slot k is picked, or when the scan reaches the
// fill count with nothing found. Scan pace is set by the single read port.
// Reset clears fill count and running task; table RAMs are not cleared since
// only slots below the fill count are ever read. Results cannot be stalled.
`default_nettype none

module task_table_scheduler_core #(
    parameter int MAX_TASKS = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire tts_pkg::request_t   request,
    output logic                     busy,
    output logic                     done,
    output tts_pkg::response_t       response
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    tts_pkg::fsm_state_t  state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 run_valid_reg, run_valid_next;
    logic [IDX_W-1:0]     run_slot_reg, run_slot_next;
    logic [tts_pkg::PT_W-1:0] run_pt_reg, run_pt_next;
    tts_pkg::func_t       func_reg, func_next;
    logic [IDX_W-1:0]     prev_reg, prev_next;
    logic                 done_reg, done_next;
    tts_pkg::response_t   rsp_reg, rsp_next;

    logic                 accept;
    logic                 full;
    logic                 need_scan;

    logic                 sst_we;
    logic [IDX_W-1:0]     sst_waddr;
    logic [tts_pkg::SST_W-1:0] sst_wdata;
    logic [IDX_W-1:0]     sst_raddr;
    logic [tts_pkg::SST_W-1:0] sst_rdata;

    logic                 pt_we;
    logic [tts_pkg::PT_W-1:0] pt_rdata;

    logic                 scan_clear;
    logic                 scan_enable;
    logic [IDX_W-1:0]     hit_slot;
    tts_pkg::scan_status_t scan_sts;

    function automatic tts_pkg::response_t make_rsp(
        input tts_pkg::status_t        sts,
        input logic [CNT_W-1:0]        id,
        input logic [IDX_W-1:0]        prev,
        input logic                    valid,
        input logic [IDX_W-1:0]        slot,
        input logic [tts_pkg::PT_W-1:0] pt
    );
        tts_pkg::response_t r;
        r.status         = sts;
        r.task_id        = tts_pkg::TASK_ID_W'(id);
        r.prev_slot      = tts_pkg::SLOT_W'(prev);
        r.run_valid      = valid;
        r.run_slot       = valid ? tts_pkg::SLOT_W'(slot) : '0;
        r.run_page_table = valid ? pt : '0;
        return r;
    endfunction

    assign accept = start && (state_reg == tts_pkg::ST_IDLE);
    assign full   = (count_reg == CNT_W'(MAX_TASKS));

    always_comb
    begin
        need_scan = 1'b0;
        case (request.func) inside
            tts_pkg::FUNC_PREEMPT, tts_pkg::FUNC_FINISH: need_scan = run_valid_reg;
            tts_pkg::FUNC_DISPATCH:                      need_scan = !run_valid_reg;
            default:                                     need_scan = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (accept && need_scan)
                begin
                    state_next = tts_pkg::ST_SCAN;
                end
            end
            tts_pkg::ST_SCAN:
            begin
                if (scan_sts.hit)
                begin
                    state_next = tts_pkg::ST_START;
                end
                else if (scan_sts.none)
                begin
                    state_next = tts_pkg::ST_IDLE;
                end
            end
            tts_pkg::ST_START:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        count_next     = count_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        run_pt_next    = run_pt_reg;
        func_next      = func_reg;
        prev_next      = prev_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        sst_we         = 1'b0;
        sst_waddr      = run_slot_reg;
        sst_wdata      = tts_pkg::SLOT_QUEUED;
        pt_we          = 1'b0;
        scan_clear     = 1'b0;
        scan_enable    = 1'b0;
        unique case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next  = request.func;
                    prev_next  = '0;
                    scan_clear = 1'b1;
                    case (request.func)
                        tts_pkg::FUNC_QUEUE:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                rsp_next = make_rsp(tts_pkg::STS_FULL, '0, '0,
                                    run_valid_reg, run_slot_reg, run_pt_reg);
                            end
                            else
                            begin
                                sst_we     = 1'b1;
                                sst_waddr  = count_reg[IDX_W-1:0];
                                sst_wdata  = tts_pkg::SLOT_QUEUED;
                                pt_we      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                rsp_next   = make_rsp(tts_pkg::STS_QUEUED,
                                    count_reg + CNT_W'(1), '0,
                                    run_valid_reg, run_slot_reg, run_pt_reg);
                            end
                        end
                        tts_pkg::FUNC_PREEMPT:
                        begin
                            if (!run_valid_reg)
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(tts_pkg::STS_NOT_RUN, '0, '0,
                                    1'b0, '0, '0);
                            end
                        end
                        tts_pkg::FUNC_FINISH:
                        begin
                            if (!run_valid_reg)
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(tts_pkg::STS_NOT_RUN, '0, '0,
                                    1'b0, '0, '0);
                            end
                            else
                            begin
                                // retire now; the scan looks for queued slots only
                                sst_we         = 1'b1;
                                sst_waddr      = run_slot_reg;
                                sst_wdata      = tts_pkg::SLOT_FINISHED;
                                prev_next      = run_slot_reg;
                                run_valid_next = 1'b0;
                                run_slot_next  = '0;
                            end
                        end
                        default:
                        begin
                            if (run_valid_reg)
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(tts_pkg::STS_NO_OTHER, '0, '0,
                                    run_valid_reg, run_slot_reg, run_pt_reg);
                            end
                        end
                    endcase
                end
            end
            tts_pkg::ST_SCAN:
            begin
                scan_enable = 1'b1;
                if (scan_sts.hit)
                begin
                    if (func_reg == tts_pkg::FUNC_PREEMPT)
                    begin
                        sst_we    = 1'b1;
                        sst_waddr = run_slot_reg;
                        sst_wdata = tts_pkg::SLOT_PAUSED;
                        prev_next = run_slot_reg;
                    end
                end
                else if (scan_sts.none)
                begin
                    done_next = 1'b1;
                    if (func_reg == tts_pkg::FUNC_PREEMPT)
                    begin
                        rsp_next = make_rsp(tts_pkg::STS_NO_OTHER, '0, '0,
                            run_valid_reg, run_slot_reg, run_pt_reg);
                    end
                    else
                    begin
                        rsp_next = make_rsp(tts_pkg::STS_IDLE, '0, prev_reg,
                            1'b0, '0, '0);
                    end
                end
            end
            tts_pkg::ST_START:
            begin
                // page table read of the picked slot lands this cycle
                sst_we         = 1'b1;
                sst_waddr      = hit_slot;
                sst_wdata      = tts_pkg::SLOT_RUNNING;
                run_valid_next = 1'b1;
                run_slot_next  = hit_slot;
                run_pt_next    = pt_rdata;
                done_next      = 1'b1;
                rsp_next       = make_rsp(tts_pkg::STS_SWITCHED, '0, prev_reg,
                    1'b1, hit_slot, pt_rdata);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tts_pkg::ST_IDLE;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            func_reg      <= tts_pkg::FUNC_QUEUE;
            prev_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            func_reg      <= func_next;
            prev_reg      <= prev_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_pt_reg <= run_pt_next;
        rsp_reg    <= rsp_next;
    end

    tts_ram #(
        .WIDTH (tts_pkg::SST_W),
        .DEPTH (MAX_TASKS)
    ) u_state_ram (
        .clk   (clk),
        .we    (sst_we),
        .waddr (sst_waddr),
        .wdata (sst_wdata),
        .raddr (sst_raddr),
        .rdata (sst_rdata)
    );

    tts_ram #(
        .WIDTH (tts_pkg::PT_W),
        .DEPTH (MAX_TASKS)
    ) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (request.page_table_addr),
        .raddr (hit_slot),
        .rdata (pt_rdata)
    );

    tts_scan #(
        .MAX_TASKS (MAX_TASKS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (scan_clear),
        .enable       (scan_enable),
        .count        (count_reg),
        .allow_paused (func_reg == tts_pkg::FUNC_PREEMPT),
        .use_skip     (func_reg == tts_pkg::FUNC_PREEMPT),
        .skip_slot    (run_slot_reg),
        .rd_data      (sst_rdata),
        .rd_addr      (sst_raddr),
        .hit_slot     (hit_slot),
        .status       (scan_sts)
    );

    assign busy     = (state_reg != tts_pkg::ST_IDLE);
    assign done     = done_reg;
    assign response = rsp_reg;

    // results always arrive with the sequencer back at idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == tts_pkg::ST_IDLE))
        else $error("result transfer while sequencer busy");

    a_run_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> ({1'b0, run_slot_reg} < {1'b0, count_reg}))
        else $error("running slot beyond fill count");

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tts_pkg::ST_START) |=> (done_reg && run_valid_reg))
        else $error("task start without result");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("fill count over capacity");

    a_scan_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(scan_sts.hit && scan_sts.none))
        else $error("scan reports hit and none together");

endmodule

`default_nettype wire

### rtl/tts_ram.sv
// ----------------------------------------------------------------------------
// tts_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/tts_scan.sv
// ----------------------------------------------------------------------------
// tts_scan
// Linear slot search: one state read issued and one slot checked per cycle while enabled and no hit is found.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_scan #(
    parameter int MAX_TASKS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              clear,
    input  wire logic                              enable,
    input  wire logic [$clog2(MAX_TASKS+1)-1:0]    count,
    input  wire logic                              allow_paused,
    input  wire logic                              use_skip,
    input  wire logic [$clog2(MAX_TASKS)-1:0]      skip_slot,
    input  wire logic [tts_pkg::SST_W-1:0]         rd_data,
    output logic      [$clog2(MAX_TASKS)-1:0]      rd_addr,
    output logic      [$clog2(MAX_TASKS)-1:0]      hit_slot,
    output tts_pkg::scan_status_t                  status
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             issue;
    logic             match;
    logic             hit;

    // read data belongs to the slot issued in the previous cycle
    always_comb
    begin
        match = (rd_data == tts_pkg::SLOT_QUEUED)
             || (allow_paused && (rd_data == tts_pkg::SLOT_PAUSED));
        if (use_skip && (chk_idx_reg == skip_slot))
        begin
            match = 1'b0;
        end
    end

    assign hit   = enable && chk_valid_reg && match;
    assign issue = enable && !hit && (rd_idx_reg < count);

    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        if (clear)
        begin
            rd_idx_next    = '0;
            chk_valid_next = 1'b0;
        end
        else if (enable && !hit)
        begin
            chk_valid_next = issue;
            if (issue)
            begin
                chk_idx_next = rd_idx_reg[IDX_W-1:0];
                rd_idx_next  = rd_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg   <= chk_idx_next;
        end
    end

    assign rd_addr     = rd_idx_reg[IDX_W-1:0];
    assign hit_slot    = chk_idx_reg;
    assign status.hit  = hit;
    assign status.none = enable && !hit && (rd_idx_reg == count);

endmodule

`default_nettype wire
